### src/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants, cell setup type and pattern byte selection for the
// reverse substring search block.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int BYTE_W       = 8;
	localparam int PATTERN_BYTES = 16;
	localparam int PAT_W        = PATTERN_BYTES * BYTE_W;
	localparam int PAT_IDX_W    = 7;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 2;
	localparam int LENGTH_W     = 5;
	localparam int START_W      = 18;

	localparam int DEF_MAX_PATTERN_BYTES = 16;
	localparam int DEF_MAX_TEXT_BYTES    = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_LIMIT    = 2'd3;

	typedef struct packed {
		logic              active;
		logic [BYTE_W-1:0] pat;
	} cell_cfg_t;

	// Pattern bytes beyond the stored sixteen read as zero.
	function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
			input logic [PAT_IDX_W-1:0] k);
		logic [BYTE_W-1:0] b;
		b = '0;
		if (k < PAT_IDX_W'(PATTERN_BYTES)) begin
			b = pat[k[3:0]*BYTE_W +: BYTE_W];
		end
		return b;
	endfunction

endpackage

### src/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell
// One window cell: hold a text byte, pass it on, compare the incoming byte.
// ----------------------------------------------------------------------------
module rss_cell
	import rss_pkg::*;
(
	input  logic              clk,
	input  logic              shift_en,
	input  logic [BYTE_W-1:0] data_in,
	input  cell_cfg_t         cfg,
	output logic [BYTE_W-1:0] data_q,
	output logic              ok
);

	// advance the window on every counted transfer
	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= data_in;
		end
	end

	// an inactive cell lies outside the pattern and never blocks a match
	assign ok = !cfg.active || (data_in == cfg.pat);

endmodule

### src/rss_cfg.sv
// ----------------------------------------------------------------------------
// rss_cfg
// Configuration registers and per-cell pattern byte setup.
// ----------------------------------------------------------------------------
module rss_cfg
	import rss_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cell_cfg_t             cell_cfg [MAX_PATTERN_BYTES],
	output logic [LEN_W-1:0]      len_eff,
	output logic [START_W-1:0]    start_limit
);

	localparam int CW = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;

	logic [PAT_W-1:0]    pattern_q;
	logic [LENGTH_W-1:0] pattern_length_q;
	logic [START_W-1:0]  start_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q        <= '0;
			pattern_length_q <= LENGTH_W'(1);
			start_limit_q    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    pattern_q[CFG_DATA_W-1:0]     <= cfg_data;
				REG_PATTERN_HIGH:   pattern_q[PAT_W-1:CFG_DATA_W] <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LENGTH_W-1:0];
				REG_START_LIMIT:    start_limit_q    <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the length to the number of cells
	always_comb begin
		if (CW'(pattern_length_q) > CW'(MAX_PATTERN_BYTES)) begin
			len_eff = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = LEN_W'(pattern_length_q);
		end
	end

	assign start_limit = start_limit_q;

	// cell j holds the byte that pattern byte (len - 1 - j) must equal
	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_setup
		logic [LEN_W-1:0] k;
		assign k = len_eff - LEN_W'(j) - LEN_W'(1);
		always_comb begin
			cell_cfg[j].active = (LEN_W'(j) < len_eff);
			cell_cfg[j].pat    = pattern_byte(pattern_q, PAT_IDX_W'(k));
		end
	end

endmodule

### src/reverse_substring_search.sv
// ----------------------------------------------------------------------------
// reverse_substring_search
// Streams a text a byte per transfer through a chain of compare cells and
// reports the 1-based start of the last pattern match at or before the
// configured start limit (anywhere if it is negative), one result per text.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  text     | text_valid / text_ready     | text_byte, last_byte
//  result   | result_valid / result_ready | match_position
//  cfg      | cfg_we (no wait)            | cfg_index, cfg_data
//
//  One text byte per cycle while text_ready is high. A byte is compared in the cycle of its transfer:
//  the cell chain sees the shifted window and the match position is judged
//  against the start limit before the edge, so no byte waits for another.
//  The result appears in the cycle after the transfer of the last byte and sits
//  in a single output register; text_ready drops only while that register is
//  full and not being taken.
//  Reset clears the byte count, the best match and the result valid flag.
//  The window bytes are not cleared: a match is judged only once enough bytes
//  of the current text have been counted.
// ----------------------------------------------------------------------------
module reverse_substring_search
	import rss_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
	parameter int MAX_TEXT_BYTES    = DEF_MAX_TEXT_BYTES,
	localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  last_byte,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [CNT_W-1:0]      match_position
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int CMP_W = ((CNT_W > START_W - 1) ? CNT_W : START_W - 1) + 1;

	cell_cfg_t          cell_cfg [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0]   len_eff;
	logic [START_W-1:0] start_limit;

	logic [BYTE_W-1:0]  cell_in   [MAX_PATTERN_BYTES];
	logic [BYTE_W-1:0]  cell_data [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] cell_ok;

	logic              accept;
	logic              counting;
	logic              shift_en;
	logic [CNT_W-1:0]  bytes_seen_q;
	logic [CNT_W-1:0]  best_match_q;
	logic [CNT_W-1:0]  bytes_next;
	logic [CMP_W-1:0]  bytes_next_w;
	logic [CMP_W-1:0]  len_w;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  sl_mag;
	logic              sl_neg;
	logic              sl_zero;
	logic              allowed;
	logic              hit;
	logic [CNT_W-1:0]  best_next;
	logic [CNT_W-1:0]  result;
	logic              result_valid_q;
	logic [CNT_W-1:0]  match_position_q;

	rss_cfg #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_cfg   (cell_cfg),
		.len_eff    (len_eff),
		.start_limit(start_limit)
	);

	// take a byte whenever the result register can make room
	assign text_ready = !result_valid_q || result_ready;
	assign accept     = text_valid && text_ready;

	// bytes beyond the text limit are neither counted nor compared
	assign counting = bytes_seen_q < CNT_W'(MAX_TEXT_BYTES);
	assign shift_en = accept && counting;

	// the newest byte enters cell 0; each cell hands its byte to the next
	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_chain
		if (j == 0) begin : g_head
			assign cell_in[j] = text_byte;
		end else begin : g_link
			assign cell_in[j] = cell_data[j-1];
		end
		rss_cell u_cell (
			.clk     (clk),
			.shift_en(shift_en),
			.data_in (cell_in[j]),
			.cfg     (cell_cfg[j]),
			.data_q  (cell_data[j]),
			.ok      (cell_ok[j])
		);
	end

	assign bytes_next   = counting ? (bytes_seen_q + CNT_W'(1)) : bytes_seen_q;
	assign bytes_next_w = CMP_W'(bytes_next);
	assign len_w        = CMP_W'(len_eff);
	assign pos_w        = bytes_next_w - len_w + CMP_W'(1);

	// a negative limit searches from the end; zero allows nothing
	assign sl_neg  = start_limit[START_W-1];
	assign sl_zero = (start_limit == '0);
	assign sl_mag  = CMP_W'(start_limit[START_W-2:0]);
	assign allowed = sl_neg || (!sl_zero && (pos_w <= sl_mag));

	assign hit = counting && (len_eff != '0) && (bytes_next_w >= len_w)
		&& (&cell_ok) && allowed;

	assign best_next = hit ? CNT_W'(pos_w) : best_match_q;

	always_comb begin
		if (sl_zero) begin
			result = '0;
		end else if (!sl_neg && (sl_mag > bytes_next_w)) begin
			result = '0;
		end else begin
			result = best_next;
		end
	end

	// hold the text state; drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			best_match_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				bytes_seen_q <= '0;
				best_match_q <= '0;
			end else begin
				bytes_seen_q <= bytes_next;
				best_match_q <= best_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			match_position_q <= result;
		end
	end

	assign result_valid   = result_valid_q;
	assign match_position = match_position_q;

	// a last byte always leaves a result behind
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> result_valid)
		else $error("no result after last byte");

	// the text state is dropped after the last byte
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> (bytes_seen_q == '0) && (best_match_q == '0))
		else $error("text state not cleared");

	// a recorded match never starts past the counted bytes
	a_best_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		best_match_q <= bytes_seen_q)
		else $error("best match beyond text");

	// the counter never passes the text limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= CNT_W'(MAX_TEXT_BYTES))
		else $error("byte count overflow");

	// a zero start limit always reports no match
	a_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte && sl_zero |=> match_position == '0)
		else $error("match reported with zero start");

endmodule

### tb/rss_position_checker.sv
// ----------------------------------------------------------------------------
// rss_position_checker
// Watches the text, result and register write ports of the reverse substring
// search block, keeps its own copy of the search state, and compares every
// result transfer with the oldest predicted match position.
// ----------------------------------------------------------------------------
module rss_position_checker
	import rss_pkg::*;
#(
	parameter int MAX_TEXT = DEF_MAX_TEXT_BYTES,
	parameter int POS_W    = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  text_valid,
	input  logic                  text_ready,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  last_byte,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic [POS_W-1:0]      match_position,
	output int                    failures,
	output int                    outstanding
);

	logic [PAT_W-1:0]    pat_bytes;
	logic [LENGTH_W-1:0] pat_len;
	int                  start_lim;
	logic [BYTE_W-1:0]   recent [PATTERN_BYTES];
	int                  text_count;
	int                  latest_hit;
	logic [POS_W-1:0]    expected_positions [$];
	logic [POS_W-1:0]    want_pos;

	task automatic clear_text();
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			recent[i] = '0;
		end
		text_count = 0;
		latest_hit = 0;
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// Shift one byte into the window, judge a match ending here, and on the
	// final byte queue the position that the block must report.
	task automatic take_byte(input logic [BYTE_W-1:0] b, input logic last);
		int  len;
		int  p;
		int  result;
		logic hit;
		len = (pat_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(pat_len);
		if (text_count < MAX_TEXT) begin
			for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
				recent[i] = recent[i-1];
			end
			recent[0] = b;
			text_count++;
			if (len != 0 && text_count >= len) begin
				hit = 1'b1;
				for (int k = 0; k < len; k++) begin
					if (recent[len-1-k] != pat_bytes[8*k +: 8]) begin
						hit = 1'b0;
					end
				end
				p = text_count - len + 1;
				if (hit && (start_lim < 0 || (start_lim > 0 && p <= start_lim))) begin
					latest_hit = p;
				end
			end
		end
		if (last) begin
			if (start_lim == 0) begin
				result = 0;
			end else if (start_lim > 0 && start_lim > text_count) begin
				result = 0;
			end else begin
				result = latest_hit;
			end
			expected_positions.push_back(POS_W'(result));
			clear_text();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes = '0;
			pat_len   = LENGTH_W'(1);
			start_lim = -1;
			clear_text();
			expected_positions.delete();
			failures     = 0;
			outstanding <= 0;
		end else begin
			// Results first: a result at this edge can only belong to an
			// earlier text.
			if (result_valid && result_ready) begin
				if (expected_positions.size() == 0) begin
					note_failure($sformatf("unexpected result: match_position %0d",
						match_position));
				end else begin
					want_pos = expected_positions.pop_front();
					if (match_position !== want_pos) begin
						note_failure($sformatf("match_position: expected %0d, got %0d",
							want_pos, match_position));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN_LOW:    pat_bytes[63:0]   = cfg_data;
					REG_PATTERN_HIGH:   pat_bytes[127:64] = cfg_data;
					REG_PATTERN_LENGTH: pat_len           = cfg_data[LENGTH_W-1:0];
					REG_START_LIMIT:    start_lim = int'($signed(cfg_data[START_W-1:0]));
					default: ;
				endcase
			end
			if (text_valid && text_ready) begin
				take_byte(text_byte, last_byte);
			end
			outstanding <= expected_positions.size();
		end
	end

endmodule

### tb/tb_reverse_substring_search.sv
// ----------------------------------------------------------------------------
// tb_reverse_substring_search
// Drives texts through the reverse substring search block under a range of
// patterns and start limits, with random idling on both channels; a checker
// beside the block predicts each match position and counts errors.
// ----------------------------------------------------------------------------
module tb_reverse_substring_search;
	import rss_pkg::*;

	localparam int POS_W        = 17;
	localparam int RANDOM_ITEMS = 900;
	localparam int CALM_ITEMS   = 780;   // idling stops past this many items

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  text_valid   = 1'b0;
	logic                  text_ready;
	logic [BYTE_W-1:0]     text_byte    = '0;
	logic                  last_byte    = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [POS_W-1:0]      match_position;

	int   failures;
	int   outstanding;
	bit   idling = 1'b1;
	int   items_sent;
	int   ready_hold;

	// Current search settings, kept so that texts can be built around them.
	logic [PAT_W-1:0]    cur_pat;
	logic [LENGTH_W-1:0] cur_len;
	logic [BYTE_W-1:0]   sym_a;
	logic [BYTE_W-1:0]   sym_b;

	always #4 clk = ~clk;

	reverse_substring_search DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_valid     (text_valid),
		.text_ready     (text_ready),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.match_position (match_position)
	);

	rss_position_checker #(
		.POS_W (POS_W)
	) position_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_valid     (text_valid),
		.text_ready     (text_ready),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.match_position (match_position),
		.failures       (failures),
		.outstanding    (outstanding)
	);

	// Result side: stall at random while idling is on,
	// otherwise take every result at once.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_hold   <= 0;
		end else if (ready_hold != 0) begin
			result_ready <= 1'b0;
			ready_hold   <= ready_hold - 1;
		end else if (idling && $urandom_range(0, 4) == 0) begin
			result_ready <= 1'b0;
			ready_hold   <= $urandom_range(0, 2);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Stream one text, a transfer per byte, marking the final byte. Valid
	// stays high across back-to-back bytes unless a gap is drawn.
	task automatic send_text(input logic [BYTE_W-1:0] txt[$]);
		foreach (txt[i]) begin
			if (idling && $urandom_range(0, 3) == 0) begin
				text_valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			text_valid <= 1'b1;
			text_byte  <= txt[i];
			last_byte  <= (i == txt.size() - 1);
			do @(posedge clk); while (!text_ready);
			items_sent++;
		end
	endtask

	// Drop valid and hold until every predicted result has been taken, then
	// let the output register settle.
	task automatic wait_idle();
		text_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all four registers back to back on an idle block.
	task automatic new_settings(input logic [PAT_W-1:0] pat, input logic [LENGTH_W-1:0] len,
			input int start);
		wait_idle();
		cur_pat   = pat;
		cur_len   = len;
		cfg_we    <= 1'b1;
		cfg_index <= REG_PATTERN_LOW;
		cfg_data  <= pat[63:0];
		@(posedge clk);
		cfg_index <= REG_PATTERN_HIGH;
		cfg_data  <= pat[127:64];
		@(posedge clk);
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data  <= CFG_DATA_W'(len);
		@(posedge clk);
		cfg_index <= REG_START_LIMIT;
		cfg_data  <= CFG_DATA_W'(start[START_W-1:0]);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [BYTE_W-1:0] tq [$];
		logic [PAT_W-1:0]  pat;
		logic [LENGTH_W-1:0] len;
		int                start;
		int                sel;
		int                tlen;
		int                eff;
		int                off;
		bit                first;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: single zero byte, search from the end.
		tq = {8'h00, 8'hFF};
		send_text(tq);

		// Two-byte pattern "AB", search from the end: last hit at 4.
		new_settings(PAT_W'(16'h4241), 5'd2, -1);
		tq = {8'h41, 8'h42, 8'h78, 8'h41, 8'h42};
		send_text(tq);

		// Start limit zero: always nothing.
		new_settings(PAT_W'(16'h4241), 5'd2, 0);
		tq = {8'h41, 8'h42};
		send_text(tq);

		// Start limit past the end of the text: nothing, despite the hit.
		new_settings(PAT_W'(16'h4241), 5'd2, 3);
		send_text(tq);

		// Start limit cuts off the later of two hits.
		new_settings(PAT_W'(16'h4241), 5'd2, 2);
		tq = {8'h41, 8'h42, 8'h41, 8'h42};
		send_text(tq);

		// Pattern longer than the text.
		new_settings(PAT_W'(40'h4142414241), 5'd5, -1);
		tq = {8'h41, 8'h42, 8'h41};
		send_text(tq);

		// Zero pattern length never matches.
		new_settings(PAT_W'(40'h4142414241), 5'd0, -1);
		tq = {8'h41};
		send_text(tq);

		// Length above sixteen saturates: a text equal to the full pattern
		// hits at 1. Force the byte extremes into the pattern.
		pat = {$urandom, $urandom, $urandom, $urandom};
		pat[7:0]     = 8'hFF;
		pat[127:120] = 8'h00;
		new_settings(pat, 5'd31, -1);
		tq.delete();
		for (int k = 0; k < PATTERN_BYTES; k++) begin
			tq.push_back(pat[8*k +: 8]);
		end
		send_text(tq);

		// Random texts over a two-symbol alphabet so that matches are common,
		// with some noise bytes and planted copies of the pattern.
		items_sent = 0;
		first      = 1'b1;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent > CALM_ITEMS) begin
				idling = 1'b0;
			end
			if (first || $urandom_range(0, 2) == 0) begin
				first = 1'b0;
				sym_a = BYTE_W'($urandom);
				sym_b = BYTE_W'($urandom);
				for (int k = 0; k < PATTERN_BYTES; k++) begin
					pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
				end
				sel = $urandom_range(0, 19);
				if (sel == 0) begin
					len = 5'd0;
				end else if (sel == 1) begin
					len = LENGTH_W'($urandom_range(17, 31));
				end else if (sel < 12) begin
					len = LENGTH_W'($urandom_range(1, 4));
				end else begin
					len = LENGTH_W'($urandom_range(1, 16));
				end
				sel = $urandom_range(0, 9);
				if (sel < 4) begin
					start = -1;
				end else if (sel == 4) begin
					start = 0;
				end else if (sel == 5) begin
					start = DEF_MAX_TEXT_BYTES;
				end else if (sel == 6) begin
					start = -$urandom_range(2, 131072);
				end else begin
					start = $urandom_range(1, 24);
				end
				new_settings(pat, len, start);
			end
			tq.delete();
			tlen = $urandom_range(1, 20);
			for (int i = 0; i < tlen; i++) begin
				sel = $urandom_range(0, 9);
				if (sel < 2) begin
					tq.push_back(BYTE_W'($urandom));
				end else if (sel < 6) begin
					tq.push_back(sym_a);
				end else begin
					tq.push_back(sym_b);
				end
			end
			eff = (cur_len > PATTERN_BYTES) ? PATTERN_BYTES : int'(cur_len);
			if (eff != 0 && eff <= tlen && $urandom_range(0, 1) == 1) begin
				off = $urandom_range(0, tlen - eff);
				for (int k = 0; k < eff; k++) begin
					tq[off+k] = cur_pat[8*k +: 8];
				end
			end
			send_text(tq);
		end

		wait_idle();
		if (failures == 0) begin
			$display("reverse_substring_search: match");
		end else begin
			$display("reverse_substring_search: mismatch");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#12000000;
		$display("reverse_substring_search: mismatch");
		$finish;
	end

endmodule
